[src/lei_pkg.sv]
// ---------------------------------------------------------------------------
// Lorenz Euler integrator package
// Shared widths, register indexes and the saturating add used by the block.
// ---------------------------------------------------------------------------
package lei_pkg;

   localparam int DATA_W            = 32;
   localparam int STEP_W            = 31;
   localparam int COUNT_W           = 16;
   localparam int FRAC_BITS_DEFAULT = 20;
   localparam int REQ_DATA_W        = 8;
   localparam int RSP_DATA_W        = COUNT_W + 6 * DATA_W;
   localparam int CSR_INDEX_W       = 3;

   typedef logic signed [DATA_W-1:0] sword_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_SIZE  = 3'd0,
      CSR_SIGMA_GAIN = 3'd1,
      CSR_RHO_GAIN   = 3'd2,
      CSR_BETA_GAIN  = 3'd3,
      CSR_START_X    = 3'd4,
      CSR_START_Y    = 3'd5,
      CSR_START_Z    = 3'd6,
      CSR_STEP_LIMIT = 3'd7
   } csr_index_type;

   localparam sword_type SWORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam sword_type SWORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   function automatic sword_type sat_add(input sword_type a, input sword_type b,
                                         input logic sub);
      logic signed [DATA_W:0] sum;
      sum = sub ? ({a[DATA_W-1], a} - {b[DATA_W-1], b})
                : ({a[DATA_W-1], a} + {b[DATA_W-1], b});
      if (sum[DATA_W] != sum[DATA_W-1]) begin
         return sum[DATA_W] ? SWORD_MIN : SWORD_MAX;
      end
      return sum[DATA_W-1:0];
   endfunction

endpackage

[src/lorenz_euler_integrator.sv]
// ---------------------------------------------------------------------------
// Lorenz Euler integrator
// Forward-Euler stepping of the Lorenz system in signed fixed point.
// ---------------------------------------------------------------------------
// An advance beat (restart bit low) keeps the block busy from acceptance
// through DIFF, SIG, RHO, XY, BETA, EMIT, HX, HY, HZ and UPDZ, and no new
// beat is taken before it is back in idle: seven products go one after
// another through a single registered 32x32 multiplier, since the derivative
// terms feed the point update and each step needs the point left by the one
// before. The result beat is formed in EMIT, after DIFF to BETA, and is held
// in an output register, so the block only waits there if the previous
// result has not yet been taken. A restart beat, or an advance beat after
// step_limit steps, is taken in idle and produces no result beat.
module lorenz_euler_integrator #(
   parameter int FRAC_BITS = lei_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lei_pkg::REQ_DATA_W-1:0]    req_tdata,  // restart
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // step_index, x_out, y_out, z_out, x_rate, y_rate, z_rate
   output logic [lei_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,  // last_step
   input  logic                              csr_we,
   input  logic [lei_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lei_pkg::DATA_W-1:0]        csr_wdata
);
   import lei_pkg::*;

   localparam logic [63:0] RST_H     = ((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam logic [63:0] RST_SIGMA = 64'd10 << FRAC_BITS;
   localparam logic [63:0] RST_RHO   = 64'd28 << FRAC_BITS;
   localparam logic [63:0] RST_BETA  = (64'd2 * (64'd8 << FRAC_BITS) + 64'd3) / 64'd6;
   localparam logic [63:0] RST_X     =
      ((64'd1000001 << FRAC_BITS) + 64'd500000) / 64'd1000000;
   localparam logic [63:0] RST_Y     = ((64'd12 << FRAC_BITS) + 64'd5) / 64'd10;
   localparam logic [63:0] RST_Z     = ((64'd17 << FRAC_BITS) + 64'd5) / 64'd10;
   localparam logic [COUNT_W-1:0] RST_LIMIT = COUNT_W'(16198);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_DIFF = 11'b000_0000_0010,
      ST_SIG  = 11'b000_0000_0100,
      ST_RHO  = 11'b000_0000_1000,
      ST_XY   = 11'b000_0001_0000,
      ST_BETA = 11'b000_0010_0000,
      ST_EMIT = 11'b000_0100_0000,
      ST_HX   = 11'b000_1000_0000,
      ST_HY   = 11'b001_0000_0000,
      ST_HZ   = 11'b010_0000_0000,
      ST_UPDZ = 11'b100_0000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_size_ff;
   sword_type             sigma_ff, rho_ff, beta_ff;
   sword_type             start_x_ff, start_y_ff, start_z_ff;
   logic [COUNT_W-1:0]    step_limit_ff;

   sword_type             x_ff, y_ff, z_ff;
   logic [COUNT_W-1:0]    count_ff;
   sword_type             ta_ff, dx_ff, dy_ff, dz_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   sword_type             mul_a, mul_b, scaled;
   sword_type             add_a, add_b, add_out;
   logic                  add_sub;
   logic                  req_fire, rsp_load;
   logic [COUNT_W:0]      count_next;

   lei_mul_unit #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .scaled (scaled)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign count_next = {1'b0, count_ff} + 1'b1;
   assign add_out    = sat_add(add_a, add_b, add_sub);

   always_comb begin
      mul_a   = x_ff;
      mul_b   = y_ff;
      add_a   = y_ff;
      add_b   = x_ff;
      add_sub = 1'b1;
      unique case (state_ff)
         ST_SIG: begin
            mul_a = sigma_ff;
            mul_b = ta_ff;
            add_a = rho_ff;
            add_b = z_ff;
         end
         ST_RHO: begin
            mul_b = ta_ff;
         end
         ST_XY: begin
            add_a = scaled;
            add_b = y_ff;
         end
         ST_BETA, ST_EMIT: begin
            mul_a = beta_ff;
            mul_b = z_ff;
            add_a = ta_ff;
            add_b = scaled;
         end
         ST_HX: begin
            mul_a = {1'b0, step_size_ff};
            mul_b = dx_ff;
         end
         ST_HY: begin
            mul_a   = {1'b0, step_size_ff};
            mul_b   = dy_ff;
            add_a   = x_ff;
            add_b   = scaled;
            add_sub = 1'b0;
         end
         ST_HZ: begin
            mul_a   = {1'b0, step_size_ff};
            mul_b   = dz_ff;
            add_a   = y_ff;
            add_b   = scaled;
            add_sub = 1'b0;
         end
         ST_UPDZ: begin
            add_a   = z_ff;
            add_b   = scaled;
            add_sub = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !req_tdata[0] && (count_ff < step_limit_ff)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: state_in = ST_SIG;
         ST_SIG:  state_in = ST_RHO;
         ST_RHO:  state_in = ST_XY;
         ST_XY:   state_in = ST_BETA;
         ST_BETA: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_load) begin
               state_in = ST_HX;
            end
         end
         ST_HX:   state_in = ST_HY;
         ST_HY:   state_in = ST_HZ;
         ST_HZ:   state_in = ST_UPDZ;
         ST_UPDZ: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_size_ff  <= RST_H[STEP_W-1:0];
         sigma_ff      <= RST_SIGMA[DATA_W-1:0];
         rho_ff        <= RST_RHO[DATA_W-1:0];
         beta_ff       <= RST_BETA[DATA_W-1:0];
         start_x_ff    <= RST_X[DATA_W-1:0];
         start_y_ff    <= RST_Y[DATA_W-1:0];
         start_z_ff    <= RST_Z[DATA_W-1:0];
         step_limit_ff <= RST_LIMIT;
         x_ff          <= RST_X[DATA_W-1:0];
         y_ff          <= RST_Y[DATA_W-1:0];
         z_ff          <= RST_Z[DATA_W-1:0];
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_STEP_SIZE:  step_size_ff  <= csr_wdata[STEP_W-1:0];
               CSR_SIGMA_GAIN: sigma_ff      <= csr_wdata;
               CSR_RHO_GAIN:   rho_ff        <= csr_wdata;
               CSR_BETA_GAIN:  beta_ff       <= csr_wdata;
               CSR_START_X:    start_x_ff    <= csr_wdata;
               CSR_START_Y:    start_y_ff    <= csr_wdata;
               CSR_START_Z:    start_z_ff    <= csr_wdata;
               CSR_STEP_LIMIT: step_limit_ff <= csr_wdata[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_fire && req_tdata[0]) begin
            x_ff     <= start_x_ff;
            y_ff     <= start_y_ff;
            z_ff     <= start_z_ff;
            count_ff <= '0;
         end
         if (state_ff == ST_HY) begin
            x_ff <= add_out;
         end
         if (state_ff == ST_HZ) begin
            y_ff <= add_out;
         end
         if (state_ff == ST_UPDZ) begin
            z_ff     <= add_out;
            count_ff <= count_next[COUNT_W-1:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIFF) || (state_ff == ST_SIG)) begin
         ta_ff <= add_out;
      end
      if (state_ff == ST_BETA) begin
         ta_ff <= scaled;
      end
      if (state_ff == ST_RHO) begin
         dx_ff <= scaled;
      end
      if (state_ff == ST_XY) begin
         dy_ff <= add_out;
      end
      if (rsp_load) begin
         dz_ff       <= add_out;
         rsp_data_ff <= {add_out, dy_ff, dx_ff, z_ff, y_ff, x_ff, count_ff};
         rsp_last_ff <= (count_next == {1'b0, step_limit_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result beat raised outside the emit step");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |-> $past(count_ff < step_limit_ff))
      else $error("advance started with the step count exhausted");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tdata[0]) |=> (count_ff == '0 && state_ff == ST_IDLE))
      else $error("restart did not clear the step count");

   a_point_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |=> $stable(x_ff) && $stable(z_ff))
      else $error("point changed while the result was being formed");

endmodule

[src/lei_mul_unit.sv]
// ---------------------------------------------------------------------------
// Lorenz Euler integrator shared multiplier
// Registered signed 32x32 product, then arithmetic shift and saturation.
// ---------------------------------------------------------------------------
module lei_mul_unit #(
   parameter int FRAC_BITS = lei_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  lei_pkg::sword_type mul_a,
   input  lei_pkg::sword_type mul_b,
   output lei_pkg::sword_type scaled
);
   import lei_pkg::*;

   localparam int PROD_W = 2 * DATA_W;
   localparam logic signed [PROD_W-1:0] PROD_MAX =
      {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] PROD_MIN =
      {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] shifted;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign shifted = prod_ff >>> FRAC_BITS;

   always_comb begin
      if (shifted > PROD_MAX) begin
         scaled = SWORD_MAX;
      end else if (shifted < PROD_MIN) begin
         scaled = SWORD_MIN;
      end else begin
         scaled = shifted[DATA_W-1:0];
      end
   end

endmodule

[tb/lorenz_euler_integrator_checker.sv]
// ---------------------------------------------------------------------------
// Lorenz Euler integrator checker
// Watches the request, result and register channels of the integrator and
// keeps its own copy of the trajectory state and the register values.
// Each accepted advance beat within the step limit yields an expected
// sample. Each result beat is compared field by field with the oldest one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lorenz_euler_integrator_checker #(
   parameter int FRAC_BITS = lei_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lei_pkg::REQ_DATA_W-1:0]  req_tdata,  // restart
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // step_index, x_out, y_out, z_out, x_rate, y_rate, z_rate
   input  logic [lei_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tlast,  // last_step
   input  logic                            csr_we,
   input  logic [lei_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lei_pkg::DATA_W-1:0]      csr_wdata,
   output int                              mismatch_count,
   output int                              samples_outstanding
);
   import lei_pkg::*;

   typedef logic signed [63:0] wide_type;

   typedef struct packed {
      logic [COUNT_W-1:0] step_index;
      sword_type          x_out;
      sword_type          y_out;
      sword_type          z_out;
      sword_type          x_rate;
      sword_type          y_rate;
      sword_type          z_rate;
      logic               last_step;
   } trajectory_sample_type;

   logic [STEP_W-1:0]  h_step;
   sword_type          sigma_gain;
   sword_type          rho_gain;
   sword_type          beta_gain;
   sword_type          start_x;
   sword_type          start_y;
   sword_type          start_z;
   logic [COUNT_W-1:0] step_limit;
   sword_type          point_x;
   sword_type          point_y;
   sword_type          point_z;
   logic [COUNT_W-1:0] step_count;

   trajectory_sample_type expected_samples[$];
   trajectory_sample_type want;
   trajectory_sample_type got;
   int                    errors = 0;

   function automatic sword_type clamp32(input wide_type v);
      if (v > wide_type'(SWORD_MAX)) begin
         return SWORD_MAX;
      end
      if (v < wide_type'(SWORD_MIN)) begin
         return SWORD_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic sword_type qprod(input wide_type a, input wide_type b);
      wide_type p;
      p = a * b;
      return clamp32(p >>> FRAC_BITS);
   endfunction

   task automatic load_defaults();
      wide_type v;
      v          = ((wide_type'(5) <<< FRAC_BITS) + 500) / 1000;
      h_step     = v[STEP_W-1:0];
      v          = wide_type'(10) <<< FRAC_BITS;
      sigma_gain = v[DATA_W-1:0];
      v          = wide_type'(28) <<< FRAC_BITS;
      rho_gain   = v[DATA_W-1:0];
      v          = (2 * (wide_type'(8) <<< FRAC_BITS) + 3) / 6;
      beta_gain  = v[DATA_W-1:0];
      v          = ((wide_type'(1000001) <<< FRAC_BITS) + 500000) / 1000000;
      start_x    = v[DATA_W-1:0];
      v          = ((wide_type'(12) <<< FRAC_BITS) + 5) / 10;
      start_y    = v[DATA_W-1:0];
      v          = ((wide_type'(17) <<< FRAC_BITS) + 5) / 10;
      start_z    = v[DATA_W-1:0];
      step_limit = 16'd16198;
      point_x    = start_x;
      point_y    = start_y;
      point_z    = start_z;
      step_count = '0;
   endtask

   task automatic advance_point();
      wide_type              wx;
      wide_type              wy;
      wide_type              wz;
      wide_type              dx;
      wide_type              dy;
      wide_type              dz;
      wide_type              h;
      trajectory_sample_type s;
      if (step_count < step_limit) begin
         wx = wide_type'(point_x);
         wy = wide_type'(point_y);
         wz = wide_type'(point_z);
         h  = {33'd0, h_step};
         dx = wide_type'(qprod(wide_type'(sigma_gain), wide_type'(clamp32(wy - wx))));
         dy = wide_type'(qprod(wx, wide_type'(clamp32(wide_type'(rho_gain) - wz))));
         dy = wide_type'(clamp32(dy - wy));
         dz = wide_type'(qprod(wx, wy));
         dz = wide_type'(clamp32(dz - wide_type'(qprod(wide_type'(beta_gain), wz))));
         s.step_index = step_count;
         s.x_out      = wx[DATA_W-1:0];
         s.y_out      = wy[DATA_W-1:0];
         s.z_out      = wz[DATA_W-1:0];
         s.x_rate     = dx[DATA_W-1:0];
         s.y_rate     = dy[DATA_W-1:0];
         s.z_rate     = dz[DATA_W-1:0];
         s.last_step  = (({1'b0, step_count} + 17'd1) == {1'b0, step_limit});
         expected_samples.push_back(s);
         point_x    = clamp32(wx + wide_type'(qprod(h, dx)));
         point_y    = clamp32(wy + wide_type'(qprod(h, dy)));
         point_z    = clamp32(wz + wide_type'(qprod(h, dz)));
         step_count = step_count + 1'b1;
      end
   endtask

   task automatic compare_field(input string name, input wide_type expected_value,
                                input wide_type actual_value);
      if (expected_value !== actual_value) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected_value,
                actual_value);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_defaults();
         expected_samples.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_STEP_SIZE:  h_step     = csr_wdata[STEP_W-1:0];
               CSR_SIGMA_GAIN: sigma_gain = csr_wdata;
               CSR_RHO_GAIN:   rho_gain   = csr_wdata;
               CSR_BETA_GAIN:  beta_gain  = csr_wdata;
               CSR_START_X:    start_x    = csr_wdata;
               CSR_START_Y:    start_y    = csr_wdata;
               CSR_START_Z:    start_z    = csr_wdata;
               CSR_STEP_LIMIT: step_limit = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tdata[0]) begin
               point_x    = start_x;
               point_y    = start_y;
               point_z    = start_z;
               step_count = '0;
            end else begin
               advance_point();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.step_index = rsp_tdata[COUNT_W-1:0];
            got.x_out      = rsp_tdata[COUNT_W + 0*DATA_W +: DATA_W];
            got.y_out      = rsp_tdata[COUNT_W + 1*DATA_W +: DATA_W];
            got.z_out      = rsp_tdata[COUNT_W + 2*DATA_W +: DATA_W];
            got.x_rate     = rsp_tdata[COUNT_W + 3*DATA_W +: DATA_W];
            got.y_rate     = rsp_tdata[COUNT_W + 4*DATA_W +: DATA_W];
            got.z_rate     = rsp_tdata[COUNT_W + 5*DATA_W +: DATA_W];
            got.last_step  = rsp_tlast;
            if (expected_samples.size() == 0) begin
               $error("Result beat with step_index %0d arrived with none expected",
                      got.step_index);
               errors++;
            end else begin
               want = expected_samples.pop_front();
               compare_field("step_index", wide_type'(want.step_index),
                             wide_type'(got.step_index));
               compare_field("x_out", wide_type'(want.x_out), wide_type'(got.x_out));
               compare_field("y_out", wide_type'(want.y_out), wide_type'(got.y_out));
               compare_field("z_out", wide_type'(want.z_out), wide_type'(got.z_out));
               compare_field("x_rate", wide_type'(want.x_rate), wide_type'(got.x_rate));
               compare_field("y_rate", wide_type'(want.y_rate), wide_type'(got.y_rate));
               compare_field("z_rate", wide_type'(want.z_rate), wide_type'(got.z_rate));
               compare_field("last_step", wide_type'(want.last_step),
                             wide_type'(got.last_step));
            end
         end
      end
      samples_outstanding <= expected_samples.size();
      mismatch_count      <= errors;
   end

endmodule

[tb/lorenz_euler_integrator_test.sv]
// ---------------------------------------------------------------------------
// Lorenz Euler integrator testbench
// Drives restart and advance beats in random bursts against random result
// stalls, rewrites the registers between phases while the block is idle, and
// takes its verdict from the checker beside the block and from a watchdog.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lorenz_euler_integrator_test;
   import lei_pkg::*;

   localparam int ITEM_TARGET  = 950;
   localparam int SETTLE       = 16;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_PHASE   = 2;
   localparam int QUIET_LIMIT  = 2000;

   typedef struct packed {
      logic [STEP_W-1:0]  step_size;
      sword_type          sigma;
      sword_type          rho;
      sword_type          beta;
      sword_type          sx;
      sword_type          sy;
      sword_type          sz;
      logic [COUNT_W-1:0] step_limit;
   } lorenz_settings_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // restart
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // step_index, x_out, y_out, z_out, x_rate, y_rate, z_rate
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;   // last_step
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0]      csr_wdata;

   int mismatch_count;
   int samples_outstanding;
   int quiet_cycles = 0;

   bit                  hold_off_req = 0;
   int                  burst_left   = 0;
   int                  steps_taken  = 0;
   int                  active_limit = 16198;
   int                  useful_items = 0;
   int                  phase_useful;
   int                  phase_sent;
   int                  quota;
   int                  phase;
   lorenz_settings_type cfg;

   lorenz_euler_integrator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lorenz_euler_integrator_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tlast           (rsp_tlast),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .samples_outstanding (samples_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("lorenz_euler_integrator_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : rsp_stall
      int mode;
      int len;
      int tick;
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req && !held) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            held = 1'b1;
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(1, 40);
         for (tick = 0; tick < len; tick++) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= (tick % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic sword_type pick_coeff(input int typical, input int spread);
      case ($urandom_range(0, 9))
         0:       return SWORD_MAX;
         1:       return SWORD_MIN;
         2:       return $urandom;
         default: return typical + $signed($urandom_range(0, 2 * spread)) - spread;
      endcase
   endfunction

   function automatic lorenz_settings_type draw_settings(input bit long_run);
      lorenz_settings_type s;
      case ($urandom_range(0, 9))
         0:       s.step_size = '0;
         1:       s.step_size = '1;
         2:       s.step_size = STEP_W'($urandom);
         default: s.step_size = STEP_W'($urandom_range(1, 20000));
      endcase
      s.sigma = pick_coeff(10 << 20, 4 << 20);
      s.rho   = pick_coeff(28 << 20, 16 << 20);
      s.beta  = pick_coeff(2796203, 2 << 20);
      s.sx    = pick_coeff(0, 20 << 20);
      s.sy    = pick_coeff(0, 20 << 20);
      s.sz    = pick_coeff(0, 20 << 20);
      case ($urandom_range(0, 11))
         0:       s.step_limit = '0;
         1:       s.step_limit = '1;
         2:       s.step_limit = 16'd1;
         default: s.step_limit = COUNT_W'($urandom_range(2, 60));
      endcase
      if (long_run) begin
         s.step_limit = '1;
      end
      return s;
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_settings(input lorenz_settings_type s);
      write_csr(CSR_STEP_SIZE, {1'($urandom), s.step_size});
      write_csr(CSR_SIGMA_GAIN, s.sigma);
      write_csr(CSR_RHO_GAIN, s.rho);
      write_csr(CSR_BETA_GAIN, s.beta);
      write_csr(CSR_START_X, s.sx);
      write_csr(CSR_START_Y, s.sy);
      write_csr(CSR_START_Z, s.sz);
      write_csr(CSR_STEP_LIMIT, {16'($urandom_range(0, 65535)), s.step_limit});
      csr_we       <= 1'b0;
      active_limit = int'(s.step_limit);
   endtask

   // An advance past the step limit is taken but does nothing, so it is not
   // counted toward the item target.
   task automatic send_item(input logic restart_bit);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, restart_bit};
      do @(posedge clock); while (!req_tready);
      phase_sent++;
      if (restart_bit) begin
         steps_taken = 0;
         phase_useful++;
      end else if (steps_taken < active_limit) begin
         steps_taken++;
         phase_useful++;
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (samples_outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      useful_items += phase_useful;
      phase_useful = 0;
      phase_sent   = 0;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_STEP_SIZE;
      csr_wdata  <= '0;
      phase_useful = 0;
      phase_sent   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset values: a few steps, then a restart and more steps.
      repeat (4) send_item(1'b0);
      send_item(1'b1);
      repeat (2) send_item(1'b0);
      drain_results();

      // Largest step and extreme coefficients; the third advance exceeds the limit.
      cfg = '{step_size: '1, sigma: SWORD_MIN, rho: SWORD_MAX, beta: SWORD_MIN,
              sx: SWORD_MAX, sy: SWORD_MIN, sz: '0, step_limit: 16'd2};
      write_settings(cfg);
      send_item(1'b1);
      repeat (3) send_item(1'b0);
      drain_results();

      // A step limit of zero lets no advance through.
      cfg.step_limit = '0;
      write_settings(cfg);
      repeat (2) send_item(1'b0);
      send_item(1'b1);
      send_item(1'b0);
      drain_results();

      // Zero step size with other extremes for the coefficients and start point.
      cfg = '{step_size: '0, sigma: SWORD_MAX, rho: SWORD_MIN, beta: SWORD_MAX,
              sx: SWORD_MIN, sy: SWORD_MIN, sz: SWORD_MAX, step_limit: 16'd3};
      write_settings(cfg);
      send_item(1'b1);
      repeat (3) send_item(1'b0);
      drain_results();

      phase = 0;
      while (useful_items < ITEM_TARGET) begin
         cfg = draw_settings(phase == HOLD_PHASE);
         write_settings(cfg);
         if (phase == HOLD_PHASE) begin
            hold_off_req = 1'b1;
         end
         quota = $urandom_range(30, 90);
         send_item(1'b1);
         while (phase_useful < quota && phase_sent < 3 * quota) begin
            send_item($urandom_range(0, 11) == 0);
         end
         drain_results();
         phase++;
      end

      if (mismatch_count == 0) begin
         $display("lorenz_euler_integrator_test: PASS");
      end else begin
         $display("lorenz_euler_integrator_test: FAIL");
      end
      $finish;
   end

endmodule
